// ----- design/mmcd_pkg.sv -----
`timescale 1ns / 1ps
package mmcd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned IDX_W    = 10;

  localparam int unsigned MAX_SAMPLES = 65535;
  localparam int unsigned MAX_COLUMNS = 1024;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 16'd1024;
  localparam logic [COL_W-1:0]   COLUMN_COUNT_RESET = 11'd128;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes; each register sits at four times its index.
  typedef enum logic {
    REG_SAMPLE_COUNT = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                busy;
    logic [COL_W-1:0]    active_columns;
    logic [COUNT_W-1:0]  samples_per_column;
  } geom_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       seed;
    logic                       emit;
    logic [IDX_W-1:0]           column_index;
    logic                       last;
  } q_entry_t;

  // Buffer length after saturation to the supported maximum.
  function automatic logic [COUNT_W-1:0] eff_samples(input logic [COUNT_W-1:0] sc);
    logic [COUNT_W-1:0] n;
    n = sc;
    if (32'(sc) > MAX_SAMPLES) begin
      n = COUNT_W'(MAX_SAMPLES);
    end
    return n;
  endfunction

  // Columns actually used: requested count, saturated, and never above the buffer length.
  function automatic logic [COL_W-1:0] active_cols(input logic [COL_W-1:0] cc,
                                                   input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] c;
    c = {{(COUNT_W-COL_W){1'b0}}, cc};
    if (32'(cc) > MAX_COLUMNS) begin
      c = COUNT_W'(MAX_COLUMNS);
    end
    if (n < c) begin
      c = n;
    end
    return c[COL_W-1:0];
  endfunction

endpackage

// ----- design/mmcd_geom.sv -----
`timescale 1ns / 1ps
module mmcd_geom (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write,
  input  logic [mmcd_pkg::COUNT_W-1:0] sample_count,
  input  logic [mmcd_pkg::COL_W-1:0]   column_count,
  output mmcd_pkg::geom_t              geom
);

  localparam int unsigned STEPS = mmcd_pkg::COUNT_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                         load_r, load_nxt;
  logic                         busy_r, busy_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [mmcd_pkg::COUNT_W-1:0] dq_r, dq_nxt;
  logic [mmcd_pkg::COL_W-1:0]   rem_r, rem_nxt;
  logic [mmcd_pkg::COL_W-1:0]   dvsr_r, dvsr_nxt;

  logic [mmcd_pkg::COUNT_W-1:0] n_eff;
  logic [mmcd_pkg::COL_W:0]     rem_sh;
  logic [mmcd_pkg::COL_W:0]     diff;
  logic                         ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of dq_r while quotient bits shift in at the bottom.
  always_comb begin
    n_eff    = mmcd_pkg::eff_samples(sample_count);
    rem_sh   = {rem_r, dq_r[mmcd_pkg::COUNT_W-1]};
    diff     = rem_sh - {1'b0, dvsr_r};
    ge       = rem_sh >= {1'b0, dvsr_r};
    load_nxt = cfg_write;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (load_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS - 1);
      dq_nxt   = n_eff;
      rem_nxt  = '0;
      dvsr_nxt = mmcd_pkg::active_cols(column_count, n_eff);
    end else if (busy_r) begin
      dq_nxt  = {dq_r[mmcd_pkg::COUNT_W-2:0], ge};
      rem_nxt = ge ? diff[mmcd_pkg::COL_W-1:0] : rem_sh[mmcd_pkg::COL_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b1;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      load_r <= load_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign geom.busy               = load_r | busy_r;
  assign geom.active_columns     = dvsr_r;
  assign geom.samples_per_column = (dvsr_r == '0) ? '0 : dq_r;

endmodule

// ----- design/mmcd_front.sv -----
`timescale 1ns / 1ps
module mmcd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mmcd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [mmcd_pkg::COUNT_W-1:0]        sample_count,
  input  mmcd_pkg::geom_t                     geom,
  input  logic                                q_full,
  output logic                                q_push,
  output mmcd_pkg::q_entry_t                  q_entry
);

  localparam int unsigned CW = mmcd_pkg::COUNT_W;
  localparam int unsigned LW = mmcd_pkg::COL_W;

  logic [CW-1:0] bp_r, bp_nxt;
  logic [LW-1:0] col_r, col_nxt;
  logic [CW-1:0] pic_r, pic_nxt;
  logic [LW-1:0] ac_r, ac_nxt;
  logic [CW-1:0] spc_r, spc_nxt;

  logic          take;
  logic          start;
  logic [CW-1:0] n_eff;
  logic [LW-1:0] col_cur;
  logic [CW-1:0] pic_cur;
  logic [CW:0]   pic_inc;
  logic [LW:0]   col_inc;
  logic [CW:0]   bp_inc;
  logic          in_col;
  logic          emit;

  assign in_ready = !geom.busy && !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    start   = (bp_r == '0);
    n_eff   = mmcd_pkg::eff_samples(sample_count);
    ac_nxt  = start ? geom.active_columns : ac_r;
    spc_nxt = start ? geom.samples_per_column : spc_r;
    col_cur = start ? '0 : col_r;
    pic_cur = start ? '0 : pic_r;
    pic_inc = {1'b0, pic_cur} + (CW+1)'(1);
    col_inc = {1'b0, col_cur} + (LW+1)'(1);
    bp_inc  = {1'b0, bp_r} + (CW+1)'(1);
    in_col  = (n_eff != '0) && (ac_nxt != '0) && (col_cur < ac_nxt);
    emit    = pic_inc >= {1'b0, spc_nxt};
    col_nxt = col_cur;
    pic_nxt = pic_cur;
    if (in_col) begin
      if (emit) begin
        col_nxt = col_inc[LW-1:0];
        pic_nxt = '0;
      end else begin
        pic_nxt = pic_inc[CW-1:0];
      end
    end
    if (n_eff == '0 || bp_inc >= {1'b0, n_eff}) begin
      bp_nxt = '0;
    end else begin
      bp_nxt = bp_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r  <= '0;
      col_r <= '0;
      pic_r <= '0;
      ac_r  <= '0;
      spc_r <= '0;
    end else if (take) begin
      bp_r  <= bp_nxt;
      col_r <= col_nxt;
      pic_r <= pic_nxt;
      ac_r  <= ac_nxt;
      spc_r <= spc_nxt;
    end
  end

  assign q_push               = take && in_col;
  assign q_entry.sample       = in_sample;
  assign q_entry.seed         = (pic_cur == '0);
  assign q_entry.emit         = emit;
  assign q_entry.column_index = col_cur[mmcd_pkg::IDX_W-1:0];
  assign q_entry.last         = (col_inc == {1'b0, ac_nxt});

endmodule

// ----- design/mmcd_queue.sv -----
`timescale 1ns / 1ps
module mmcd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mmcd_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output mmcd_pkg::q_entry_t head
);

  localparam int unsigned DEPTH = mmcd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  mmcd_pkg::q_entry_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_r] <= push_entry;
    end
  end

  assign full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots[rd_r];

endmodule

// ----- design/mmcd_back.sv -----
`timescale 1ns / 1ps
module mmcd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  mmcd_pkg::q_entry_t                   q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmcd_pkg::IDX_W-1:0]           out_column_index,
  output logic signed [mmcd_pkg::SAMPLE_W-1:0] out_column_min,
  output logic signed [mmcd_pkg::SAMPLE_W-1:0] out_column_max,
  output logic                                 out_last_column
);

  localparam int unsigned SW = mmcd_pkg::SAMPLE_W;

  logic signed [SW-1:0]        min_r, min_nxt;
  logic signed [SW-1:0]        max_r, max_nxt;
  logic                        ov_r, ov_nxt;
  logic [mmcd_pkg::IDX_W-1:0]  idx_r;
  logic signed [SW-1:0]        omin_r;
  logic signed [SW-1:0]        omax_r;
  logic                        olast_r;
  logic                        load_out;

  always_comb begin
    q_pop    = !q_empty && (!q_head.emit || !ov_r || out_ready);
    load_out = q_pop && q_head.emit;
    if (q_head.seed) begin
      min_nxt = q_head.sample;
      max_nxt = q_head.sample;
    end else begin
      min_nxt = (q_head.sample < min_r) ? q_head.sample : min_r;
      max_nxt = (q_head.sample > max_r) ? q_head.sample : max_r;
    end
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
    if (load_out) begin
      idx_r   <= q_head.column_index;
      omin_r  <= min_nxt;
      omax_r  <= max_nxt;
      olast_r <= q_head.last;
    end
  end

  assign out_valid        = ov_r;
  assign out_column_index = idx_r;
  assign out_column_min   = omin_r;
  assign out_column_max   = omax_r;
  assign out_last_column  = olast_r;

endmodule

// ----- design/min_max_column_decimation.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Payload
// in        sink       in_valid/ready    in_sample (16b signed)
// out       source     out_valid/ready   out_column_index, out_column_min,
//                                        out_column_max, out_last_column
// cfg       APB slave  psel/penable      sample_count @0x0, column_count @0x4
//
// One sample is accepted per cycle while in_ready is high; a column's result
// passes through the four-entry queue into the output register.
// After reset and after every register write, in_ready stays low while the
// serial divider works out samples per column (a load step, then one quotient
// bit per cycle). Output stalls fill the queue; in_ready drops only once the
// queue is full.
module min_max_column_decimation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mmcd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmcd_pkg::IDX_W-1:0]           out_column_index,
  output logic signed [mmcd_pkg::SAMPLE_W-1:0] out_column_min,
  output logic signed [mmcd_pkg::SAMPLE_W-1:0] out_column_max,
  output logic                                 out_last_column,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [mmcd_pkg::COUNT_W-1:0] sample_count_r;
  logic [mmcd_pkg::COL_W-1:0]   column_count_r;
  logic                         cfg_write;
  mmcd_pkg::reg_idx_t           reg_sel;

  mmcd_pkg::geom_t    geom;
  mmcd_pkg::q_entry_t q_entry;
  mmcd_pkg::q_entry_t q_head;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  assign pready    = 1'b1;
  // Register select is address bit 2; the byte offset bits are ignored.
  assign reg_sel   = mmcd_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // The configuration registers are plain storage. The geometry unit recomputes
  // active columns and samples per column after every write; the front end
  // picks the new geometry up at the next buffer start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= mmcd_pkg::SAMPLE_COUNT_RESET;
      column_count_r <= mmcd_pkg::COLUMN_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        mmcd_pkg::REG_SAMPLE_COUNT: sample_count_r <= pwdata[mmcd_pkg::COUNT_W-1:0];
        mmcd_pkg::REG_COLUMN_COUNT: column_count_r <= pwdata[mmcd_pkg::COL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mmcd_pkg::REG_SAMPLE_COUNT: prdata = {{(32-mmcd_pkg::COUNT_W){1'b0}}, sample_count_r};
      mmcd_pkg::REG_COLUMN_COUNT: prdata = {{(32-mmcd_pkg::COL_W){1'b0}}, column_count_r};
    endcase
  end

  mmcd_geom u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .sample_count (sample_count_r),
    .column_count (column_count_r),
    .geom         (geom)
  );

  // The front end tracks buffer and column position and tags each sample as
  // a column seed, a plain update or the column's closing sample. Tail samples
  // and samples of an empty geometry never enter the queue.
  mmcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .sample_count (sample_count_r),
    .geom         (geom),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  mmcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // The back end keeps the running minimum and maximum and loads the output
  // register when a column closes. Items that close no column drain even
  // while a result waits at the output.
  mmcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column_index (out_column_index),
    .out_column_min   (out_column_min),
    .out_column_max   (out_column_max),
    .out_last_column  (out_last_column)
  );

`ifndef SYNTH
  // A finished column can never report a minimum above its maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column_min <= out_column_max))
    else $error("column minimum above maximum");

  // The front end must not push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");

  // Once the divider is done, a nonempty geometry has at least one sample per column.
  a_geom_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (!geom.busy && geom.active_columns != '0) |-> (geom.samples_per_column != '0))
    else $error("zero samples per column with active columns");
`endif

endmodule
